### src/mono_framebuffer_blitter_core_macros.svh
// ----------------------------------------------------------------------------
// mono framebuffer blitter assertion macros
// shared concurrent assertion forms, clocked on clk_i and idle in reset
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_BLITTER_CORE_MACROS_SVH
`define MONO_FRAMEBUFFER_BLITTER_CORE_MACROS_SVH

// same-cycle implication
`define MFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// widths, store size and item codes of the mono framebuffer blitter
// ----------------------------------------------------------------------------
package mfb_pkg;

  localparam int STORE_BYTES  = 1024;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int MAX_WIDTH    = 128;
  localparam int MAX_HEIGHT   = 64;
  localparam int MIN_SIZE     = 8;
  localparam int BYTE_W       = 8;
  localparam int COORD_W      = 8;
  localparam int KIND_W       = 3;
  localparam int RADDR_W      = 10;
  localparam int WIDTH_REG_W  = 8;
  localparam int HEIGHT_REG_W = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;
  // wide enough for any page or row address before range check
  localparam int CALC_W       = $clog2((256 / 8 + 2) * 256);

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_PAGE_START = 3'd0,
    KIND_ROW_START  = 3'd1,
    KIND_DATA       = 3'd2,
    KIND_READ       = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_e;

endpackage

### src/mfb_in_if.sv
// ----------------------------------------------------------------------------
// mfb_in_if
// input item channel: valid/ready handshake with command payload
// ----------------------------------------------------------------------------
interface mfb_in_if;
  logic                               valid;
  logic                               ready;
  logic [mfb_pkg::KIND_W-1:0]         kind;
  logic [mfb_pkg::COORD_W-1:0]        start_x;
  logic [mfb_pkg::COORD_W-1:0]        start_y;
  logic [mfb_pkg::COORD_W-1:0]        rect_width;
  logic [mfb_pkg::COORD_W-1:0]        rect_height;
  logic                               invert;
  logic [mfb_pkg::BYTE_W-1:0]         data_byte;
  logic [mfb_pkg::RADDR_W-1:0]        read_address;

  modport source (
    output valid, kind, start_x, start_y, rect_width, rect_height, invert, data_byte,
           read_address,
    input  ready
  );
  modport sink (
    input  valid, kind, start_x, start_y, rect_width, rect_height, invert, data_byte,
           read_address,
    output ready
  );
endinterface

### src/mfb_out_if.sv
// ----------------------------------------------------------------------------
// mfb_out_if
// result item channel: valid/ready handshake with result payload
// ----------------------------------------------------------------------------
interface mfb_out_if;
  logic                       valid;
  logic                       ready;
  logic [mfb_pkg::BYTE_W-1:0] read_data;
  logic                       blit_done;
  logic                       data_ignored;

  modport source (output valid, read_data, blit_done, data_ignored, input ready);
  modport sink   (input valid, read_data, blit_done, data_ignored, output ready);
endinterface

### src/mono_framebuffer_blitter_core.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_blitter_core
// 1-bit framebuffer in a single-port byte store, written by clipped page or
// row blits, with byte read-back and whole-store clear
// ----------------------------------------------------------------------------
// sequence: each item is taken in idle, executed, then answered from a result state;
//   a read adds a data state, row data a write, page data a read and a merged write
//   per touched page, and clear a full clearing pass of the store
// items: one at a time, as input ready is high only in idle; the store has one port
// reset: control state clears at once, then a clearing pass zeroes the store
//   with input ready low; config writes still taken
// ----------------------------------------------------------------------------
`include "mono_framebuffer_blitter_core_macros.svh"

module mono_framebuffer_blitter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mfb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mfb_in_if.sink                         in_i,
  mfb_out_if.source                      out_o
);
  import mfb_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PAGE,
    MODE_ROW
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WR,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RDATA,
    ST_RESP
  } state_e;

  state_e                  state_q;
  mode_e                   mode_q;
  logic [ADDR_W-1:0]       clr_cnt_q;
  logic                    clr_resp_q;

  logic [WIDTH_REG_W-1:0]  screen_width_q;
  logic [HEIGHT_REG_W-1:0] screen_height_q;

  logic [KIND_W-1:0]       kind_q;
  logic [COORD_W-1:0]      sx_q, sy_q, rw_q, rh_q;
  logic                    inv_q;
  logic [BYTE_W-1:0]       dat_q;
  logic [RADDR_W-1:0]      raddr_q;

  logic [COORD_W-1:0]      cursor_x_q, cursor_y_q, origin_x_q, clip_end_x_q, clip_end_y_q;
  logic                    invert_latched_q;

  logic [CALC_W-1:0]       addr_q;
  logic [BYTE_W-1:0]       v_q;
  logic [2:0]              sh_q;
  logic                    second_q;
  logic                    half_q;

  logic [BYTE_W-1:0]       res_rdata_q;
  logic                    res_done_q, res_ign_q;

  logic                    ov_q;
  logic [BYTE_W-1:0]       out_rdata_q;
  logic                    out_done_q, out_ign_q;

  logic [BYTE_W-1:0]       mem [STORE_BYTES];
  logic [BYTE_W-1:0]       rd_q;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_addr;
  logic [BYTE_W-1:0]       mem_wdata;

  // effective screen size
  logic [WIDTH_REG_W-1:0]  eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;

  always_comb begin
    eff_w = screen_width_q;
    if (eff_w < WIDTH_REG_W'(MIN_SIZE)) eff_w = WIDTH_REG_W'(MIN_SIZE);
    if (eff_w > WIDTH_REG_W'(MAX_WIDTH)) eff_w = WIDTH_REG_W'(MAX_WIDTH);
    eff_w[2:0] = 3'd0;
    eff_h = screen_height_q;
    if (eff_h < HEIGHT_REG_W'(MIN_SIZE)) eff_h = HEIGHT_REG_W'(MIN_SIZE);
    if (eff_h > HEIGHT_REG_W'(MAX_HEIGHT)) eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
    eff_h[2:0] = 3'd0;
  end

  // shared address unit: page*w + x or y*(w/8) + x/8
  logic                    page_mode;
  logic [COORD_W-1:0]      mul_a;
  logic [WIDTH_REG_W-1:0]  mul_b;
  logic [15:0]             prod;
  logic [CALC_W-1:0]       calc_addr;

  assign page_mode = (mode_q == MODE_PAGE);

  always_comb begin
    if (page_mode) begin
      mul_a = {3'd0, cursor_y_q[7:3]};
      mul_b = eff_w;
    end else begin
      mul_a = cursor_y_q;
      mul_b = {3'd0, eff_w[7:3]};
    end
    prod = 16'(mul_a) * 16'(mul_b);
    calc_addr = prod[CALC_W-1:0]
              + (page_mode ? CALC_W'(cursor_x_q) : CALC_W'(cursor_x_q[7:3]));
  end

  // cursor stepping and rectangle clipping
  logic [COORD_W:0]        nx, ny, ex, ey;
  logic [COORD_W-1:0]      ex_c, ey_c;
  logic                    rect_empty;
  logic                    spill;
  logic [5:0]              next_page;

  always_comb begin
    nx = {1'b0, cursor_x_q} + (page_mode ? (COORD_W+1)'(1) : (COORD_W+1)'(8));
    ny = {1'b0, cursor_y_q} + (page_mode ? (COORD_W+1)'(8) : (COORD_W+1)'(1));
    ex = {1'b0, sx_q} + {1'b0, rw_q};
    ey = {1'b0, sy_q} + {1'b0, rh_q};
    ex_c = (ex > (COORD_W+1)'(eff_w)) ? eff_w : ex[COORD_W-1:0];
    ey_c = (ey > (COORD_W+1)'(eff_h)) ? COORD_W'(eff_h) : ey[COORD_W-1:0];
    rect_empty = (rw_q == '0) || (rh_q == '0) || (sx_q >= eff_w)
              || (sy_q >= COORD_W'(eff_h));
    next_page = {1'b0, cursor_y_q[7:3]} + 6'd1;
    spill = (cursor_y_q[2:0] != 3'd0) && (next_page < 6'(eff_h[6:3]));
  end

  // masked merge of the shifted byte
  logic [15:0]             shifted;
  logic [BYTE_W-1:0]       keep_hi;
  logic [BYTE_W-1:0]       merged;
  logic                    addr_ok;
  logic [CALC_W-1:0]       raddr_ext;

  always_comb begin
    shifted = {8'd0, v_q} << sh_q;
    keep_hi = 8'hff << sh_q;
    if (half_q) merged = (rd_q & keep_hi) | shifted[15:8];
    else        merged = (rd_q & ~keep_hi) | shifted[7:0];
    addr_ok   = (addr_q < CALC_W'(STORE_BYTES));
    raddr_ext = CALC_W'(raddr_q);
  end

  // store port
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = v_q;
    case (state_q)
      ST_CLEAR: begin
        mem_addr  = clr_cnt_q;
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      ST_EXEC: mem_addr = raddr_ext[ADDR_W-1:0];
      ST_WR: begin
        mem_addr = addr_q[ADDR_W-1:0];
        mem_we   = addr_ok;
      end
      ST_RMW_WR: begin
        mem_addr  = addr_q[ADDR_W-1:0];
        mem_we    = addr_ok;
        mem_wdata = merged;
      end
      default: mem_addr = addr_q[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_q <= mem[mem_addr];
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = ov_q;
  assign out_o.read_data    = out_rdata_q;
  assign out_o.blit_done    = out_done_q;
  assign out_o.data_ignored = out_ign_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_CLEAR;
      mode_q           <= MODE_IDLE;
      clr_cnt_q        <= '0;
      clr_resp_q       <= 1'b0;
      screen_width_q   <= WIDTH_REG_W'(MAX_WIDTH);
      screen_height_q  <= HEIGHT_REG_W'(MAX_HEIGHT);
      kind_q           <= '0;
      sx_q             <= '0;
      sy_q             <= '0;
      rw_q             <= '0;
      rh_q             <= '0;
      inv_q            <= 1'b0;
      dat_q            <= '0;
      raddr_q          <= '0;
      cursor_x_q       <= '0;
      cursor_y_q       <= '0;
      origin_x_q       <= '0;
      clip_end_x_q     <= '0;
      clip_end_y_q     <= '0;
      invert_latched_q <= 1'b0;
      addr_q           <= '0;
      v_q              <= '0;
      sh_q             <= '0;
      second_q         <= 1'b0;
      half_q           <= 1'b0;
      res_rdata_q      <= '0;
      res_done_q       <= 1'b0;
      res_ign_q        <= 1'b0;
      ov_q             <= 1'b0;
      out_rdata_q      <= '0;
      out_done_q       <= 1'b0;
      out_ign_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
          REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end

      if (out_o.ready && state_q != ST_RESP) ov_q <= 1'b0;

      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
          if (clr_cnt_q == ADDR_W'(STORE_BYTES - 1)) begin
            state_q <= clr_resp_q ? ST_RESP : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_i.valid) begin
            kind_q  <= in_i.kind;
            sx_q    <= in_i.start_x;
            sy_q    <= in_i.start_y;
            rw_q    <= in_i.rect_width;
            rh_q    <= in_i.rect_height;
            inv_q   <= in_i.invert;
            dat_q   <= in_i.data_byte;
            raddr_q <= in_i.read_address;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_rdata_q <= '0;
          res_done_q  <= 1'b0;
          res_ign_q   <= 1'b0;
          state_q     <= ST_RESP;
          case (kind_e'(kind_q))
            KIND_PAGE_START, KIND_ROW_START: begin
              if (rect_empty) begin
                mode_q <= MODE_IDLE;
              end else begin
                mode_q           <= (kind_e'(kind_q) == KIND_PAGE_START) ? MODE_PAGE
                                                                          : MODE_ROW;
                cursor_x_q       <= sx_q;
                cursor_y_q       <= sy_q;
                origin_x_q       <= sx_q;
                clip_end_x_q     <= ex_c;
                clip_end_y_q     <= ey_c;
                invert_latched_q <= inv_q;
              end
            end
            KIND_DATA: begin
              if (mode_q == MODE_IDLE) begin
                res_ign_q <= 1'b1;
              end else begin
                addr_q   <= calc_addr;
                v_q      <= invert_latched_q ? ~dat_q : dat_q;
                sh_q     <= cursor_y_q[2:0];
                second_q <= spill;
                half_q   <= 1'b0;
                state_q  <= page_mode ? ST_RMW_RD : ST_WR;
                if (nx < {1'b0, clip_end_x_q}) begin
                  cursor_x_q <= nx[COORD_W-1:0];
                end else if (ny < {1'b0, clip_end_y_q}) begin
                  cursor_x_q <= origin_x_q;
                  cursor_y_q <= ny[COORD_W-1:0];
                end else begin
                  mode_q     <= MODE_IDLE;
                  res_done_q <= 1'b1;
                end
              end
            end
            KIND_READ: state_q <= ST_RDATA;
            KIND_CLEAR: begin
              clr_cnt_q  <= '0;
              clr_resp_q <= 1'b1;
              state_q    <= ST_CLEAR;
            end
            default: ;
          endcase
        end
        ST_WR: state_q <= ST_RESP;
        ST_RMW_RD: state_q <= ST_RMW_WR;
        ST_RMW_WR: begin
          if (!half_q && second_q) begin
            half_q  <= 1'b1;
            addr_q  <= addr_q + CALC_W'(eff_w);
            state_q <= ST_RMW_RD;
          end else begin
            state_q <= ST_RESP;
          end
        end
        ST_RDATA: begin
          res_rdata_q <= (raddr_ext < CALC_W'(STORE_BYTES)) ? rd_q : '0;
          state_q     <= ST_RESP;
        end
        ST_RESP: begin
          if (!ov_q || out_o.ready) begin
            ov_q        <= 1'b1;
            out_rdata_q <= res_rdata_q;
            out_done_q  <= res_done_q;
            out_ign_q   <= res_ign_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `MFB_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready,
                  "input still ready after an item was taken")
  `MFB_ASSERT_NXT(a_clear_sweep_steps,
                  state_q == ST_CLEAR && clr_cnt_q != ADDR_W'(STORE_BYTES - 1),
                  clr_cnt_q == $past(clr_cnt_q) + ADDR_W'(1),
                  "clearing pass skipped an entry")
  `MFB_ASSERT_NOW(a_cursor_in_clip, mode_q != MODE_IDLE,
                  cursor_x_q < clip_end_x_q && cursor_y_q < clip_end_y_q,
                  "open blit cursor outside its clipped rectangle")
  `MFB_ASSERT_NOW(a_done_not_ignored, ov_q, !(out_done_q && out_ign_q),
                  "result both done and ignored")

endmodule
